>>> src/ffbta_pkg.sv
// Shared types and codes for the first-fit block table allocator.
// No dependencies.
`default_nettype none
package ffbta_pkg;
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESIZE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_RSZ_RD,
    S_RSZ_CHK,
    S_GAP_RD,
    S_GAP_CHK,
    S_PLACE,
    S_INS_RD,
    S_INS_WR,
    S_REFIND_RD,
    S_REFIND_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

>>> src/first_fit_block_table_allocator.sv
// First-fit block table allocator: a sorted table of (start, length) blocks
// kept in two single-port memories and walked by one sequencer. Uses ffbta_pkg.
`default_nettype none
// Each request takes one pass per table walk, a read and then a compare or
// write per entry: allocate scans for a gap then shifts entries up,
// free searches then shifts entries down, resize may do search, allocate and
// free in turn. The single read port of the block table sets the pace.
// in_ready is low from acceptance until the result beat is delivered.
// Entries at or above the block count are never read, so no clearing pass.
module first_fit_block_table_allocator #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] block_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_address,
  output logic [1:0]       status
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  logic [31:0] mem_start [TABLE_ENTRIES];
  logic [31:0] mem_len   [TABLE_ENTRIES];

  ffbta_pkg::state_t state, state_next;
  logic [CW-1:0] count;
  logic [31:0]   heap_base;
  logic [1:0]    op_kind;
  logic [31:0]   op_size, op_addr;
  logic [CW-1:0] idx, pos;
  logic [31:0]   prev_end_lo;
  logic          prev_end_hi;
  logic [32:0]   place;
  logic [31:0]   rd_start, rd_len;
  logic [31:0]   res_addr;
  logic [1:0]    res_st;

  // memory port control
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_a, wr_a;
  logic [31:0]   wr_s, wr_l;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= mem_start[rd_a];
      rd_len   <= mem_len[rd_a];
    end
    if (wr_en) begin
      mem_start[wr_a] <= wr_s;
      mem_len[wr_a]   <= wr_l;
    end
  end

  logic [32:0] rd_end;
  logic [32:0] size_ext;
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
  assign size_ext = {1'b0, op_size};
  logic [32:0] gap_end;
  assign gap_end = {prev_end_hi, prev_end_lo};
  logic [32:0] place_top;
  assign place_top = place + size_ext;

  assign in_ready  = (state == ffbta_pkg::S_IDLE);
  assign out_valid = (state == ffbta_pkg::S_DONE);
  assign result_address = res_addr;
  assign status = res_st;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ffbta_pkg::S_IDLE: begin
        if (in_valid) begin
          case (kind)
            ffbta_pkg::KIND_ALLOC: begin
              if (count == FULL_CNT) state_next = ffbta_pkg::S_DONE;
              else if (count == '0) state_next = ffbta_pkg::S_PLACE;
              else state_next = ffbta_pkg::S_GAP_RD;
            end
            ffbta_pkg::KIND_FREE, ffbta_pkg::KIND_RESIZE: begin
              state_next = (count == '0) ? ffbta_pkg::S_DONE : ffbta_pkg::S_FIND_RD;
            end
            default: state_next = ffbta_pkg::S_DONE;
          endcase
        end
      end
      ffbta_pkg::S_FIND_RD: state_next = ffbta_pkg::S_FIND_CHK;
      ffbta_pkg::S_FIND_CHK: begin
        if (rd_start == op_addr) begin
          if (op_kind == ffbta_pkg::KIND_FREE) state_next = ffbta_pkg::S_DEL_RD;
          else if (idx + 1'b1 == count) state_next = ffbta_pkg::S_DONE;
          else state_next = ffbta_pkg::S_RSZ_RD;
        end else if (idx + 1'b1 == count) state_next = ffbta_pkg::S_DONE;
        else state_next = ffbta_pkg::S_FIND_RD;
      end
      ffbta_pkg::S_RSZ_RD: state_next = ffbta_pkg::S_RSZ_CHK;
      ffbta_pkg::S_RSZ_CHK: begin
        if ({1'b0, rd_start} - {1'b0, op_addr} >= size_ext) state_next = ffbta_pkg::S_DONE;
        else if (count == FULL_CNT) state_next = ffbta_pkg::S_DONE;
        else state_next = ffbta_pkg::S_GAP_RD;
      end
      ffbta_pkg::S_GAP_RD: state_next = ffbta_pkg::S_GAP_CHK;
      ffbta_pkg::S_GAP_CHK: begin
        if (idx != '0 && gap_end <= {1'b0, rd_start} &&
            {1'b0, rd_start} - gap_end >= size_ext)
          state_next = ffbta_pkg::S_PLACE;
        else if (idx + 1'b1 == count) state_next = ffbta_pkg::S_PLACE;
        else state_next = ffbta_pkg::S_GAP_RD;
      end
      ffbta_pkg::S_PLACE: begin
        if (place[32] || place_top > 33'h1_0000_0000) state_next = ffbta_pkg::S_DONE;
        else if (pos == count) state_next = ffbta_pkg::S_INS_WR;
        else state_next = ffbta_pkg::S_INS_RD;
      end
      ffbta_pkg::S_INS_RD: state_next = ffbta_pkg::S_INS_WR;
      ffbta_pkg::S_INS_WR: begin
        if (idx == pos) begin
          state_next = (op_kind == ffbta_pkg::KIND_RESIZE) ?
                       ffbta_pkg::S_REFIND_RD : ffbta_pkg::S_DONE;
        end else if (idx - 1'b1 == pos) state_next = ffbta_pkg::S_INS_WR;
        else state_next = ffbta_pkg::S_INS_RD;
      end
      ffbta_pkg::S_REFIND_RD: state_next = ffbta_pkg::S_REFIND_CHK;
      ffbta_pkg::S_REFIND_CHK: begin
        if (rd_start == op_addr) state_next = ffbta_pkg::S_DEL_RD;
        else state_next = ffbta_pkg::S_REFIND_RD;
      end
      ffbta_pkg::S_DEL_RD: begin
        state_next = (idx + 1'b1 == count) ? ffbta_pkg::S_DONE : ffbta_pkg::S_DEL_WR;
      end
      ffbta_pkg::S_DEL_WR: state_next = ffbta_pkg::S_DEL_RD;
      ffbta_pkg::S_DONE: if (out_ready) state_next = ffbta_pkg::S_IDLE;
      default: state_next = ffbta_pkg::S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    rd_en = 1'b0;
    rd_a  = idx[IW-1:0];
    wr_en = 1'b0;
    wr_a  = idx[IW-1:0];
    wr_s  = rd_start;
    wr_l  = rd_len;
    case (state)
      ffbta_pkg::S_FIND_RD, ffbta_pkg::S_GAP_RD, ffbta_pkg::S_REFIND_RD: rd_en = 1'b1;
      ffbta_pkg::S_RSZ_RD: begin
        rd_en = 1'b1;
        rd_a  = IW'(idx + 1'b1);
      end
      ffbta_pkg::S_INS_RD: begin
        rd_en = 1'b1;
        rd_a  = IW'(idx - 1'b1);
      end
      ffbta_pkg::S_DEL_RD: begin
        rd_en = (idx + 1'b1 != count);
        rd_a  = IW'(idx + 1'b1);
      end
      ffbta_pkg::S_INS_WR: begin
        wr_en = 1'b1;
        if (idx == pos) begin
          wr_s = place[31:0];
          wr_l = op_size;
        end
      end
      ffbta_pkg::S_DEL_WR: wr_en = 1'b1;
      ffbta_pkg::S_FIND_CHK: begin
        // in-place resize of the last block
        if (rd_start == op_addr && op_kind == ffbta_pkg::KIND_RESIZE &&
            idx + 1'b1 == count && {1'b0, rd_start} + size_ext <= 33'h1_0000_0000) begin
          wr_en = 1'b1;
          wr_s  = rd_start;
          wr_l  = op_size;
        end
      end
      ffbta_pkg::S_RSZ_CHK: begin
        if ({1'b0, rd_start} - {1'b0, op_addr} >= size_ext) begin
          wr_en = 1'b1;
          wr_s  = op_addr;
          wr_l  = op_size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffbta_pkg::S_IDLE;
      count     <= '0;
      heap_base <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) heap_base <= cfg_wdata;
      case (state)
        ffbta_pkg::S_INS_WR: if (idx == pos) count <= count + 1'b1;
        ffbta_pkg::S_DEL_RD: if (idx + 1'b1 == count) count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ffbta_pkg::S_IDLE: begin
        op_kind  <= kind;
        op_size  <= request_size;
        op_addr  <= block_address;
        idx      <= '0;
        res_addr <= '0;
        res_st   <= ffbta_pkg::ST_OK;
        place    <= {1'b0, heap_base};
        pos      <= '0;
        if (kind == ffbta_pkg::KIND_ALLOC && count == FULL_CNT) res_st <= ffbta_pkg::ST_FULL;
        if ((kind == ffbta_pkg::KIND_FREE || kind == ffbta_pkg::KIND_RESIZE) && count == '0)
          res_st <= ffbta_pkg::ST_NOT_FOUND;
      end
      ffbta_pkg::S_FIND_CHK: begin
        if (rd_start == op_addr) begin
          if (op_kind == ffbta_pkg::KIND_RESIZE && idx + 1'b1 == count) begin
            if ({1'b0, rd_start} + size_ext > 33'h1_0000_0000) res_st <= ffbta_pkg::ST_OVERFLOW;
            else res_addr <= op_addr;
          end
        end else if (idx + 1'b1 == count) res_st <= ffbta_pkg::ST_NOT_FOUND;
        else idx <= idx + 1'b1;
      end
      ffbta_pkg::S_RSZ_CHK: begin
        if ({1'b0, rd_start} - {1'b0, op_addr} >= size_ext) res_addr <= op_addr;
        else if (count == FULL_CNT) res_st <= ffbta_pkg::ST_FULL;
        else idx <= '0;
      end
      ffbta_pkg::S_GAP_CHK: begin
        prev_end_lo <= rd_end[31:0];
        prev_end_hi <= rd_end[32];
        if (idx != '0 && gap_end <= {1'b0, rd_start} &&
            {1'b0, rd_start} - gap_end >= size_ext) begin
          place <= gap_end;
          pos   <= idx;
          idx   <= count;
        end else if (idx + 1'b1 == count) begin
          place <= rd_end;
          pos   <= count;
          idx   <= count;
        end else idx <= idx + 1'b1;
      end
      ffbta_pkg::S_PLACE: begin
        idx <= count;
        if (place[32] || place_top > 33'h1_0000_0000) res_st <= ffbta_pkg::ST_OVERFLOW;
        else res_addr <= place[31:0];
      end
      ffbta_pkg::S_INS_WR: begin
        if (idx == pos) idx <= '0;
        else idx <= idx - 1'b1;
      end
      ffbta_pkg::S_REFIND_CHK: if (rd_start != op_addr) idx <= idx + 1'b1;
      ffbta_pkg::S_DEL_WR: idx <= idx + 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("block count above table size");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second request while busy");
  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ffbta_pkg::ST_OK |-> result_address == 32'd0)
    else $error("nonzero address with error status");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("block count jumped");
`endif
endmodule
`default_nettype wire
